[rtl/stbr_pkg.sv]
// Package for the stick-to-button remapper: configuration types, mapping codes
// and the function that applies one direction mapping. Depends on nothing.
`timescale 1ns / 1ps

package stbr_pkg;

    localparam int MASK_W = 17;
    localparam int DELAY_W = 31;
    localparam int BTN_W = 32;
    localparam int AXIS_W = 8;
    localparam int TIME_W = 32;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 31;

    localparam logic [AXIS_W-1:0] AXIS_CENTER = 8'd127;
    localparam logic [AXIS_W-1:0] AXIS_MAX = 8'd255;

    // Negative mapping codes that select an analog direction.
    localparam logic signed [MASK_W-1:0] CODE_UP = -17'sd1;
    localparam logic signed [MASK_W-1:0] CODE_DOWN = -17'sd2;
    localparam logic signed [MASK_W-1:0] CODE_LEFT = -17'sd3;
    localparam logic signed [MASK_W-1:0] CODE_RIGHT = -17'sd4;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_REMAP_ENABLE = 3'd0,
        CFG_TRIGGER_MASK_ONE = 3'd1,
        CFG_TRIGGER_MASK_TWO = 3'd2,
        CFG_HOLD_DELAY = 3'd3,
        CFG_MAP_RIGHT = 3'd4,
        CFG_MAP_LEFT = 3'd5,
        CFG_MAP_UP = 3'd6,
        CFG_MAP_DOWN = 3'd7
    } cfg_idx_t;

    typedef struct packed {
        logic remap_enable;
        logic signed [MASK_W-1:0] trigger_mask_one;
        logic signed [MASK_W-1:0] trigger_mask_two;
        logic [DELAY_W-1:0] hold_delay;
        logic signed [MASK_W-1:0] map_right;
        logic signed [MASK_W-1:0] map_left;
        logic signed [MASK_W-1:0] map_up;
        logic signed [MASK_W-1:0] map_down;
    } cfg_t;

    typedef struct packed {
        logic [BTN_W-1:0] buttons;
        logic [AXIS_W-1:0] left_x;
        logic [AXIS_W-1:0] left_y;
        logic [AXIS_W-1:0] right_x;
        logic [AXIS_W-1:0] right_y;
        logic [TIME_W-1:0] time_now;
    } sample_t;

    typedef struct packed {
        logic [BTN_W-1:0] buttons;
        logic [AXIS_W-1:0] left_x;
        logic [AXIS_W-1:0] left_y;
        logic [AXIS_W-1:0] right_x;
        logic [AXIS_W-1:0] right_y;
    } result_t;

    typedef struct packed {
        logic up;
        logic down;
        logic left;
        logic right;
    } dir_t;

    typedef struct packed {
        logic [BTN_W-1:0] buttons;
        logic [AXIS_W-1:0] target;
    } map_res_t;

    function automatic logic [BTN_W-1:0] sext_mask(input logic signed [MASK_W-1:0] m);
        return {{(BTN_W-MASK_W){m[MASK_W-1]}}, m};
    endfunction

    // One mapping: a positive code ORs a mask on its own direction, a
    // direction code writes the target axis. With mirror set, up and left
    // give 255 minus the value and down and right the plain value.
    function automatic map_res_t apply_map(
        input logic signed [MASK_W-1:0] code,
        input logic btn_cond,
        input dir_t dir,
        input logic [AXIS_W-1:0] rx,
        input logic [AXIS_W-1:0] ry,
        input logic mirror,
        input map_res_t cur
    );
        map_res_t r;
        r = cur;
        if (!code[MASK_W-1] && (code != '0)) begin
            if (btn_cond) begin
                r.buttons = cur.buttons | {{(BTN_W-MASK_W){1'b0}}, code};
            end
        end else if (code == CODE_UP) begin
            if (dir.up) r.target = mirror ? (AXIS_MAX - ry) : ry;
        end else if (code == CODE_DOWN) begin
            if (dir.down) r.target = mirror ? ry : (AXIS_MAX - ry);
        end else if (code == CODE_LEFT) begin
            if (dir.left) r.target = mirror ? (AXIS_MAX - rx) : rx;
        end else if (code == CODE_RIGHT) begin
            if (dir.right) r.target = mirror ? rx : (AXIS_MAX - rx);
        end
        return r;
    endfunction

endpackage

[rtl/stbr_calc.sv]
// Combinational remapping of one registered sample.
// Depends on stbr_pkg.
`timescale 1ns / 1ps

module stbr_calc #(
    parameter int DEAD_ZONE = 32
) (
    input  stbr_pkg::sample_t smp,
    input  stbr_pkg::cfg_t cfg,
    input  logic [stbr_pkg::TIME_W-1:0] last_rest,
    output logic at_rest,
    output stbr_pkg::result_t res
);
    import stbr_pkg::*;

    localparam logic [AXIS_W-1:0] HI = AXIS_W'(127 + DEAD_ZONE);
    localparam logic [AXIS_W-1:0] LO = AXIS_W'(127 - DEAD_ZONE);

    logic deflected;
    logic delay_done;
    logic [TIME_W-1:0] rest_time;
    logic [TIME_W-1:0] due_time;
    dir_t dir;
    map_res_t mx;
    map_res_t my;
    logic [BTN_W-1:0] btn;

    always_comb
    begin
        at_rest = (smp.right_x <= HI) && (smp.right_x > LO)
               && (smp.right_y <= HI) && (smp.right_y > LO);
        deflected = (smp.right_x >= HI) || (smp.right_x < LO)
                 || (smp.right_y >= HI) || (smp.right_y < LO);
        // A sample at rest restarts the hold timer before the delay test.
        rest_time = at_rest ? smp.time_now : last_rest;
        due_time = rest_time + {1'b0, cfg.hold_delay};
        delay_done = smp.time_now >= due_time;

        dir.up = smp.right_y <= LO;
        dir.down = smp.right_y >= HI;
        dir.left = smp.right_x <= LO;
        dir.right = smp.right_x >= HI;

        btn = smp.buttons;
        mx = '{buttons: '0, target: smp.left_x};
        my = '{buttons: '0, target: smp.left_y};
        if (cfg.remap_enable && deflected) begin
            btn = btn | sext_mask(cfg.trigger_mask_one) | sext_mask(cfg.trigger_mask_two);
            if (delay_done) begin
                mx.buttons = btn;
                mx = apply_map(cfg.map_right, dir.right, dir, smp.right_x, smp.right_y,
                               1'b1, mx);
                mx = apply_map(cfg.map_left, dir.left, dir, smp.right_x, smp.right_y,
                               1'b0, mx);
                my.buttons = mx.buttons;
                my = apply_map(cfg.map_up, dir.up, dir, smp.right_x, smp.right_y,
                               1'b0, my);
                my = apply_map(cfg.map_down, dir.down, dir, smp.right_x, smp.right_y,
                               1'b1, my);
                btn = my.buttons;
            end
        end

        res.buttons = btn;
        res.left_x = mx.target;
        res.left_y = my.target;
        res.right_x = smp.right_x;
        res.right_y = smp.right_y;
    end

endmodule

[rtl/stick_to_button_remapper_core.sv]
// Top level of the stick-to-button remapper: input register, remap logic,
// result register and configuration registers. Depends on stbr_pkg, stbr_calc.
`timescale 1ns / 1ps

// Channel   Handshake              Payload
// -------   --------------------   ---------------------------------------------
// input     in_valid / in_stall    buttons_in, left_x_in, left_y_in, right_x_in,
//                                  right_y_in, time_now
// output    out_valid / out_stall  buttons_out, left_x_out, left_y_out,
//                                  right_x_out, right_y_out
// config    cfg_we                 cfg_index, cfg_data
//
// One sample per cycle is accepted while in_stall is low. A sample transfer
// lands in the input register; the remap logic works from it and the result
// lands in the output register when the output can advance. The only state
// carried from one sample to the next is the last rest time stamp, updated in
// the same cycle a sample at rest with remapping enabled moves into the output
// register. Reset clears the configuration, the rest time stamp and both valid
// flags. in_stall rises only when both registers are full and out_stall is high.

module stick_to_button_remapper_core #(
    parameter int DEAD_ZONE = 32
) (
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    output logic in_stall,
    input  logic [stbr_pkg::BTN_W-1:0] buttons_in,
    input  logic [stbr_pkg::AXIS_W-1:0] left_x_in,
    input  logic [stbr_pkg::AXIS_W-1:0] left_y_in,
    input  logic [stbr_pkg::AXIS_W-1:0] right_x_in,
    input  logic [stbr_pkg::AXIS_W-1:0] right_y_in,
    input  logic [stbr_pkg::TIME_W-1:0] time_now,
    output logic out_valid,
    input  logic out_stall,
    output logic [stbr_pkg::BTN_W-1:0] buttons_out,
    output logic [stbr_pkg::AXIS_W-1:0] left_x_out,
    output logic [stbr_pkg::AXIS_W-1:0] left_y_out,
    output logic [stbr_pkg::AXIS_W-1:0] right_x_out,
    output logic [stbr_pkg::AXIS_W-1:0] right_y_out,
    input  logic cfg_we,
    input  logic [stbr_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [stbr_pkg::CFG_DATA_W-1:0] cfg_data
);
    import stbr_pkg::*;

    cfg_t cfg_reg;
    sample_t s1_reg;
    logic s1_valid_reg;
    result_t res_reg;
    logic out_valid_reg;
    logic [TIME_W-1:0] last_rest_reg;

    result_t res_next;
    logic at_rest;
    logic out_advance;
    logic in_advance;
    logic s1_move;

    // The output register can take a new result when empty or being drained.
    // The input register can take a sample when empty or moving forward.
    assign out_advance = !out_valid_reg || !out_stall;
    assign in_advance = !s1_valid_reg || out_advance;
    assign s1_move = s1_valid_reg && out_advance;
    assign in_stall = !in_advance;

    stbr_calc #(
        .DEAD_ZONE(DEAD_ZONE)
    ) u_calc (
        .smp(s1_reg),
        .cfg(cfg_reg),
        .last_rest(last_rest_reg),
        .at_rest(at_rest),
        .res(res_next)
    );

    // Config regs; user writes only while no sample is in flight; not enforced.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            cfg_reg <= '0;
        end else if (cfg_we) begin
            case (cfg_idx_t'(cfg_index))
                CFG_REMAP_ENABLE:     cfg_reg.remap_enable <= cfg_data[0];
                CFG_TRIGGER_MASK_ONE: cfg_reg.trigger_mask_one <= cfg_data[MASK_W-1:0];
                CFG_TRIGGER_MASK_TWO: cfg_reg.trigger_mask_two <= cfg_data[MASK_W-1:0];
                CFG_HOLD_DELAY:       cfg_reg.hold_delay <= cfg_data[DELAY_W-1:0];
                CFG_MAP_RIGHT:        cfg_reg.map_right <= cfg_data[MASK_W-1:0];
                CFG_MAP_LEFT:         cfg_reg.map_left <= cfg_data[MASK_W-1:0];
                CFG_MAP_UP:           cfg_reg.map_up <= cfg_data[MASK_W-1:0];
                CFG_MAP_DOWN:         cfg_reg.map_down <= cfg_data[MASK_W-1:0];
                default:              cfg_reg <= cfg_reg;
            endcase
        end
    end

    // Valid flags and the rest time stamp.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            s1_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
            last_rest_reg <= '0;
        end else begin
            if (in_advance) begin
                s1_valid_reg <= in_valid;
            end
            if (out_advance) begin
                out_valid_reg <= s1_valid_reg;
            end
            if (s1_move && cfg_reg.remap_enable && at_rest) begin
                last_rest_reg <= s1_reg.time_now;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (in_advance && in_valid) begin
            s1_reg.buttons <= buttons_in;
            s1_reg.left_x <= left_x_in;
            s1_reg.left_y <= left_y_in;
            s1_reg.right_x <= right_x_in;
            s1_reg.right_y <= right_y_in;
            s1_reg.time_now <= time_now;
        end
        if (s1_move) begin
            res_reg <= res_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign buttons_out = res_reg.buttons;
    assign left_x_out = res_reg.left_x;
    assign left_y_out = res_reg.left_y;
    assign right_x_out = res_reg.right_x;
    assign right_y_out = res_reg.right_y;

    // The input side only stalls while a sample waits in the input register.
    assert property (@(posedge clk) disable iff (!rst_n) in_stall |-> s1_valid_reg)
        else $error("input stalled with an empty input register");

    // With remapping disabled the rest time stamp never moves.
    assert property (@(posedge clk) disable iff (!rst_n)
        !cfg_reg.remap_enable |=> $stable(last_rest_reg))
        else $error("rest time stamp changed while remapping disabled");

    // A disabled remapper passes the buttons through unchanged.
    assert property (@(posedge clk) disable iff (!rst_n)
        (s1_move && !cfg_reg.remap_enable) |=> (buttons_out == $past(s1_reg.buttons)))
        else $error("buttons altered while remapping disabled");

    // A drained output register with nothing behind it goes empty.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_stall && !s1_valid_reg) |=> !out_valid_reg)
        else $error("result repeated after transfer");

endmodule
